>>> design/bmh_pkg.sv
// Shared types, constants and status codes of the binary max-heap.
package bmh_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int KEY_W            = 32;
    localparam int COUNT_OUT_W      = 7;

    localparam logic signed [KEY_W-1:0] TOP_EMPTY = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } command_t;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] top_value;
        logic [COUNT_OUT_W-1:0]  entry_count_out;
    } out_word_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

>>> design/bmh_cmp.sv
// Shared signed key comparator used by the scan and both sift passes.
module bmh_cmp
    import bmh_pkg::*;
(
    input  logic signed [KEY_W-1:0] a,
    input  logic signed [KEY_W-1:0] b,
    output cmp_res_t                res
);

    always_comb
    begin
        res.gt = (a > b);
        res.eq = (a == b);
    end

endmodule

>>> design/binary_max_heap.sv
// Binary max-heap of signed 32-bit keys with insert and delete-by-key commands.
//
// Input words arrive on in_valid/in_ready/in_word: command 0 inserts the key, command 1
// removes the lowest-index stored entry equal to the key. Each input word yields exactly
// one output word on out_valid/out_ready/out_word carrying a status, the largest stored
// key (the minimum integer when the heap is empty) and the entry count.
// The block works on one word at a time and drops in_ready from acceptance until its
// result has been placed in the output register.
// Insert sifts up level by level: each level does one read of the parent and one
// compare-and-write step; the store has one write port and one registered read port.
// Delete scans the store one entry per cycle, reads the last entry, then sifts down
// level by level (left read, then right read and child compare where a right child
// exists, then move) and sifts up as insert does.
// A refused insert or a delete on an empty heap goes straight to the result; an absent
// key is reported once the scan reaches the entry count.
// The output register frees the sequencer from the receiver: a stalled result simply
// waits there, and the next result waits in its final state until the register empties.
// Reset empties the heap at once; the store itself is not cleared since only entries
// below the count are ever read.
module binary_max_heap
    import bmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DEL_LAST,
        S_DEL_MOVE,
        S_SD_START,
        S_SD_LEFT,
        S_SD_RIGHT,
        S_SD_DEC,
        S_SU_START,
        S_SU_CMP,
        S_RESULT
    } state_t;

    logic signed [KEY_W-1:0] heap_mem [CAPACITY];

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_word_reg, out_word_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [1:0]              status_reg, status_next;

    logic [AW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           child_idx_reg, child_idx_next;
    logic signed [KEY_W-1:0] carried_reg, carried_next;
    logic signed [KEY_W-1:0] child_val_reg, child_val_next;
    logic signed [KEY_W-1:0] top_reg, top_next;
    logic signed [KEY_W-1:0] rdata_reg;

    logic [AW-1:0]           rd_addr;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [KEY_W-1:0] wdata;

    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    cmp_res_t                cmp_res;

    logic [XW-1:0]           left_x, right_x, count_x;
    logic [AW-1:0]           parent_idx;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    bmh_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign left_x     = {1'b0, pos_reg, 1'b1};
    assign right_x    = XW'(left_x + 1'b1);
    assign count_x    = XW'(count_reg);
    assign parent_idx = AW'((pos_reg - 1'b1) >> 1);
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};

    // Operand selection for the shared comparator.
    always_comb
    begin
        cmp_a = rdata_reg;
        cmp_b = carried_reg;
        case (state_reg)
            S_SCAN:
            begin
                cmp_a = rdata_reg;
                cmp_b = carried_reg;
            end
            S_SD_RIGHT:
            begin
                cmp_a = rdata_reg;
                cmp_b = child_val_reg;
            end
            S_SD_DEC:
            begin
                cmp_a = child_val_reg;
                cmp_b = carried_reg;
            end
            S_SU_CMP:
            begin
                cmp_a = carried_reg;
                cmp_b = rdata_reg;
            end
            default:
            begin
                cmp_a = rdata_reg;
                cmp_b = carried_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        status_next    = status_reg;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        child_idx_next = child_idx_reg;
        carried_next   = carried_reg;
        child_val_next = child_val_reg;
        rd_addr        = '0;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = carried_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    carried_next = in_word.value;
                    status_next  = ST_DONE;
                    if (in_word.command == CMD_INSERT)
                    begin
                        if (count_reg == CAP_COUNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            pos_next   = AW'(count_reg);
                            count_next = CW'(count_reg + 1'b1);
                            state_next = S_SU_START;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_MISSING;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        scan_idx_next  = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads are issued one entry ahead of the compare.
                if (cmp_valid_reg && cmp_res.eq)
                begin
                    pos_next   = cmp_idx_reg;
                    state_next = S_DEL_LAST;
                end
                else if (scan_idx_reg == count_reg)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_RESULT;
                end
                else
                begin
                    rd_addr        = AW'(scan_idx_reg);
                    cmp_idx_next   = AW'(scan_idx_reg);
                    scan_idx_next  = CW'(scan_idx_reg + 1'b1);
                    cmp_valid_next = 1'b1;
                end
            end
            S_DEL_LAST:
            begin
                rd_addr    = AW'(count_reg - 1'b1);
                state_next = S_DEL_MOVE;
            end
            S_DEL_MOVE:
            begin
                carried_next = rdata_reg;
                count_next   = CW'(count_reg - 1'b1);
                if (CW'(pos_reg) < CW'(count_reg - 1'b1))
                begin
                    state_next = S_SD_START;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SD_START:
            begin
                if (left_x >= count_x)
                begin
                    state_next = S_SU_START;
                end
                else
                begin
                    rd_addr    = left_x[AW-1:0];
                    state_next = S_SD_LEFT;
                end
            end
            S_SD_LEFT:
            begin
                child_val_next = rdata_reg;
                child_idx_next = left_x[AW-1:0];
                if (right_x < count_x)
                begin
                    rd_addr    = right_x[AW-1:0];
                    state_next = S_SD_RIGHT;
                end
                else
                begin
                    state_next = S_SD_DEC;
                end
            end
            S_SD_RIGHT:
            begin
                // On equal children the left one is kept.
                if (cmp_res.gt)
                begin
                    child_val_next = rdata_reg;
                    child_idx_next = right_x[AW-1:0];
                end
                state_next = S_SD_DEC;
            end
            S_SD_DEC:
            begin
                if (cmp_res.gt)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = child_val_reg;
                    pos_next   = child_idx_reg;
                    state_next = S_SD_START;
                end
                else
                begin
                    state_next = S_SU_START;
                end
            end
            S_SU_START:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = carried_reg;
                    state_next = S_RESULT;
                end
                else
                begin
                    rd_addr    = parent_idx;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                we    = 1'b1;
                waddr = pos_reg;
                if (cmp_res.gt)
                begin
                    wdata      = rdata_reg;
                    pos_next   = parent_idx;
                    state_next = S_SU_START;
                end
                else
                begin
                    wdata      = carried_reg;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_word_next.status          = status_reg;
                    out_word_next.top_value       = (count_reg == '0) ? TOP_EMPTY : top_reg;
                    out_word_next.entry_count_out = count_wide[COUNT_OUT_W-1:0];
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        top_next = (we && waddr == '0) ? wdata : top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        cmp_idx_reg   <= cmp_idx_next;
        pos_reg       <= pos_next;
        child_idx_reg <= child_idx_next;
        carried_reg   <= carried_next;
        child_val_reg <= child_val_next;
        top_reg       <= top_next;
    end

    // Heap store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[waddr] <= wdata;
        end
        rdata_reg <= heap_mem[rd_addr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count beyond capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held high after a word was accepted");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> CW'(waddr) < count_reg)
        else $error("store written at or above the entry count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg <= count_reg)
        else $error("scan ran past the entry count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESULT && status_reg == ST_FULL |-> count_reg == CAP_COUNT)
        else $error("insert refused while space remained");

endmodule

>>> tb/sv/binary_max_heap_test.sv
// Self-checking testbench of the binary max-heap: directed words, then random traffic.
module binary_max_heap_test
    import bmh_pkg::*;
();

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1670;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int IDLE_PERCENT = 21;
    localparam int REPORT_LIMIT = 10;
    localparam int DIR_ROWS_N   = 20;

    localparam logic signed [KEY_W-1:0] KEY_MIN = TOP_EMPTY;
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        command_t                cmd;
        logic signed [KEY_W-1:0] value;
        int                      reps;
        int                      step;
        logic                    typed;
        out_word_t               exp;
    } dir_row_t;

    // Rows with a typed result are checked against that word, the others against the heap
    // predictor. The fill row brings the heap to exactly CAPACITY entries.
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{CMD_DELETE, 32'sd0,         1,  0, 1'b1, '{ST_MISSING, TOP_EMPTY, 7'd0}},
        '{CMD_INSERT, KEY_MIN,        1,  0, 1'b1, '{ST_DONE, KEY_MIN, 7'd1}},
        '{CMD_DELETE, KEY_MIN,        1,  0, 1'b1, '{ST_DONE, TOP_EMPTY, 7'd0}},
        '{CMD_INSERT, KEY_MAX,        1,  0, 1'b1, '{ST_DONE, KEY_MAX, 7'd1}},
        '{CMD_INSERT, KEY_MIN,        1,  0, 1'b1, '{ST_DONE, KEY_MAX, 7'd2}},
        '{CMD_INSERT, 32'sd0,         1,  0, 1'b1, '{ST_DONE, KEY_MAX, 7'd3}},
        '{CMD_INSERT, -32'sd1,        1,  0, 1'b0, '0},
        '{CMD_INSERT, 32'sh55555555,  1,  0, 1'b0, '0},
        '{CMD_INSERT, 32'shAAAAAAAA,  1,  0, 1'b0, '0},
        '{CMD_DELETE, 32'sd12345,     1,  0, 1'b1, '{ST_MISSING, KEY_MAX, 7'd6}},
        '{CMD_DELETE, KEY_MAX,        1,  0, 1'b0, '0},
        '{CMD_DELETE, -32'sd1,        1,  0, 1'b0, '0},
        '{CMD_INSERT, 32'sd7,         3,  0, 1'b0, '0},
        '{CMD_DELETE, 32'sd7,         1,  0, 1'b0, '0},
        '{CMD_INSERT, 32'sd100,       58, 1, 1'b0, '0},
        '{CMD_INSERT, KEY_MAX,        1,  0, 1'b1, '{ST_FULL, 32'sh55555555, 7'd64}},
        '{CMD_DELETE, 32'sh55555555,  1,  0, 1'b0, '0},
        '{CMD_DELETE, KEY_MIN,        1,  0, 1'b0, '0},
        '{CMD_DELETE, 32'sd999,       1,  0, 1'b0, '0},
        '{CMD_INSERT, 32'sh7FFFFFFE,  1,  0, 1'b0, '0}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    logic signed [KEY_W-1:0] heap_keys [CAPACITY];
    int        heap_size = 0;
    out_word_t pending_outcomes [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    logic      steady = 1'b0;

    binary_max_heap #(.CAPACITY(CAPACITY)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void heap_sift_up(input int start);
        logic signed [KEY_W-1:0] carried;
        int pos;
        int up;
        pos = start;
        carried = heap_keys[pos];
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (carried <= heap_keys[up])
                break;
            heap_keys[pos] = heap_keys[up];
            pos = up;
        end
        heap_keys[pos] = carried;
    endfunction

    function automatic int heap_sift_down(input int start);
        logic signed [KEY_W-1:0] carried;
        int pos;
        int child;
        pos = start;
        carried = heap_keys[pos];
        while (2 * pos + 1 < heap_size)
        begin
            child = 2 * pos + 1;
            // On equal children the left one is taken.
            if (child + 1 < heap_size && heap_keys[child + 1] > heap_keys[child])
                child = child + 1;
            if (carried >= heap_keys[child])
                break;
            heap_keys[pos] = heap_keys[child];
            pos = child;
        end
        heap_keys[pos] = carried;
        return pos;
    endfunction

    function automatic out_word_t heap_apply(input in_word_t w);
        out_word_t r;
        int hit;
        int i;
        r.status = ST_DONE;
        if (w.command == CMD_INSERT)
        begin
            if (heap_size >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                heap_keys[heap_size] = w.value;
                heap_size++;
                heap_sift_up(heap_size - 1);
            end
        end
        else
        begin
            hit = -1;
            for (i = 0; i < heap_size && hit < 0; i++)
                if (heap_keys[i] == w.value)
                    hit = i;
            if (hit < 0)
                r.status = ST_MISSING;
            else
            begin
                heap_keys[hit] = heap_keys[heap_size - 1];
                heap_size--;
                if (hit < heap_size)
                    heap_sift_up(heap_sift_down(hit));
            end
        end
        r.top_value = (heap_size == 0) ? TOP_EMPTY : heap_keys[0];
        r.entry_count_out = COUNT_OUT_W'(heap_size);
        return r;
    endfunction

    // Called just after a rising edge; valid is left high so that a following word
    // goes out without a gap.
    task automatic offer_word(input in_word_t w, input logic typed, input out_word_t typed_exp);
        out_word_t predicted;
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = heap_apply(w);
        pending_outcomes = {pending_outcomes, (typed ? typed_exp : predicted)};
    endtask

    task automatic sender_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return KEY_W'($signed($urandom_range(0, 6)) - 3);
        else if (roll < 60)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (pending_outcomes.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result word: status %0d top %0d count %0d",
                         got.status, got.top_value, got.entry_count_out);
        end
        else
        begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status || got.top_value !== want.top_value
                || got.entry_count_out !== want.entry_count_out)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: status %0d/%0d top %0d/%0d count %0d/%0d (exp/got)",
                             want.status, got.status, want.top_value, got.top_value,
                             want.entry_count_out, got.entry_count_out);
            end
        end
    endtask

    // Result side: a requested hold-off keeps ready low for a long stretch, otherwise
    // ready drops at random unless a steady stretch is running.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            check_result(out_word);
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial
    begin
        in_word_t w;
        int row;
        int k;
        int sent;
        int phase;
        int phase_len;
        int j;
        int insert_percent;
        logic calm;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS_N; row++)
        begin
            for (k = 0; k < DIR_ROWS[row].reps; k++)
            begin
                w.command = DIR_ROWS[row].cmd;
                w.value = DIR_ROWS[row].value + k * DIR_ROWS[row].step;
                offer_word(w, DIR_ROWS[row].typed, DIR_ROWS[row].exp);
                if ($urandom_range(0, 99) < IDLE_PERCENT)
                    sender_gap($urandom_range(1, 4));
            end
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (phase == 5);
            steady <= calm;
            if (phase == 2)
                hold_requests <= hold_requests + 1;
            if (phase % 9 == 4)
                wait_all_results();
            // Phases cycle through mixed traffic, filling and draining so that the
            // full and empty cases are reached again and again.
            case (phase % 4)
                1: insert_percent = 85;
                2: insert_percent = 15;
                default: insert_percent = 55;
            endcase
            phase_len = $urandom_range(20, 80);
            for (j = 0; j < phase_len && sent < RANDOM_ITEMS; j++)
            begin
                if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
                    sender_gap($urandom_range(1, 4));
                if ($urandom_range(0, 99) < insert_percent)
                begin
                    w.command = CMD_INSERT;
                    w.value = pick_key();
                end
                else
                begin
                    w.command = CMD_DELETE;
                    if (heap_size > 0 && $urandom_range(0, 99) < 80)
                        w.value = heap_keys[$urandom_range(0, heap_size - 1)];
                    else
                        w.value = pick_key();
                end
                offer_word(w, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
